// ----- hdl/ipireg_pkg.sv -----
// Shared constants, register codes and configuration struct for the PI regulator.
`default_nettype none

package ipireg_pkg;

  // Fixed field widths
  localparam int GAIN_WIDTH          = 16;
  localparam int ACC_WIDTH           = 32;
  localparam int DRIVE_WIDTH         = 16;
  localparam int CFG_DATA_WIDTH      = 32;
  localparam int CFG_INDEX_WIDTH     = 2;
  localparam int PROP_SHIFT          = 4;
  localparam int ERROR_WIDTH_DEFAULT = 16;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPPER_LIMIT = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOWER_LIMIT = 2'd3;

  // Reset values of the clamp limits
  localparam logic signed [ACC_WIDTH-1:0] UPPER_LIMIT_RESET = 32'sh7FFF_FFFF;
  localparam logic signed [ACC_WIDTH-1:0] LOWER_LIMIT_RESET = 32'sh8000_0000;

  // Configuration handed from the register file to the datapath
  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0] prop_gain;
    logic signed [GAIN_WIDTH-1:0] integ_gain;
    logic signed [ACC_WIDTH-1:0]  upper_limit;
    logic signed [ACC_WIDTH-1:0]  lower_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/ipireg_cfg.sv -----
// Configuration register file: gains and clamp limits.
`default_nettype none

module ipireg_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wen,
  input  wire logic [ipireg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [ipireg_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output ipireg_pkg::cfg_t                          cfg
);
  import ipireg_pkg::*;

  cfg_t regs;

  // Register writes, one index per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain   <= '0;
      regs.integ_gain  <= '0;
      regs.upper_limit <= UPPER_LIMIT_RESET;
      regs.lower_limit <= LOWER_LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_PROP_GAIN:   regs.prop_gain   <= cfg_data[GAIN_WIDTH-1:0];
        REG_INTEG_GAIN:  regs.integ_gain  <= cfg_data[GAIN_WIDTH-1:0];
        REG_UPPER_LIMIT: regs.upper_limit <= cfg_data[ACC_WIDTH-1:0];
        REG_LOWER_LIMIT: regs.lower_limit <= cfg_data[ACC_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ----- hdl/ipireg_core.sv -----
// PI datapath: increment, accumulate, clamp, and the regulator state.
`default_nettype none

module ipireg_core #(
  parameter int ERROR_WIDTH = ipireg_pkg::ERROR_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire ipireg_pkg::cfg_t                      cfg,
  input  wire logic                                  update,
  input  wire logic signed [ERROR_WIDTH-1:0]         error,
  output logic signed [ipireg_pkg::DRIVE_WIDTH-1:0]  drive_next
);
  import ipireg_pkg::*;

  localparam int DIFF_W   = ERROR_WIDTH + 1;
  localparam int PPROD_W  = DIFF_W + GAIN_WIDTH;
  localparam int PSHIFT_W = PPROD_W + PROP_SHIFT;
  localparam int IPROD_W  = ERROR_WIDTH + GAIN_WIDTH;
  localparam int INC_W    = PSHIFT_W + 1;
  localparam int SUM_W    = ((ACC_WIDTH > INC_W) ? ACC_WIDTH : INC_W) + 1;

  logic signed [ERROR_WIDTH-1:0] prev_error;
  logic signed [ACC_WIDTH-1:0]   accum;
  logic signed [ACC_WIDTH-1:0]   accum_next;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [PPROD_W-1:0]  pprod;
  logic signed [PSHIFT_W-1:0] pshift;
  logic signed [IPROD_W-1:0]  iprod;
  logic signed [INC_W-1:0]    inc;
  logic signed [SUM_W-1:0]    sum;

  // Increment at full width, nothing wraps
  always_comb begin
    diff   = DIFF_W'(error) - DIFF_W'(prev_error);
    pprod  = PPROD_W'(diff) * PPROD_W'(cfg.prop_gain);
    pshift = PSHIFT_W'(pprod) <<< PROP_SHIFT;
    iprod  = IPROD_W'(error) * IPROD_W'(cfg.integ_gain);
    inc    = INC_W'(pshift) + INC_W'(iprod);
    sum    = SUM_W'(accum) + SUM_W'(inc);
  end

  // Clamp: upper limit wins when the limits cross
  always_comb begin
    if (sum > SUM_W'(cfg.upper_limit)) begin
      accum_next = cfg.upper_limit;
    end else if (sum < SUM_W'(cfg.lower_limit)) begin
      accum_next = cfg.lower_limit;
    end else begin
      accum_next = sum[ACC_WIDTH-1:0];
    end
  end

  assign drive_next = accum_next[ACC_WIDTH-1 -: DRIVE_WIDTH];

  // Regulator state advances once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      accum      <= '0;
    end else if (update) begin
      prev_error <= error;
      accum      <= accum_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/incremental_pi_regulator.sv -----
// Top level of the incremental PI regulator with output clamp.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_wen              cfg_index, cfg_data
//   in       in         in_valid / in_stall  error_in
//   out      out        out_valid/ out_stall drive_out
//
// One beat per cycle sustained while drive_out is not stalled; a beat passes
// from the input register into the result register and shows on drive_out.
// The accumulator loop through the multiply, add and clamp is combinational
// between the state registers, which sets the rate.
// Reset clears gains, state and valids and loads the clamp limits to full range.
// A stalled output holds its beat; the input register keeps taking a beat
// while it is empty or moving forward.
`default_nettype none

module incremental_pi_regulator #(
  parameter int ERROR_WIDTH = ipireg_pkg::ERROR_WIDTH_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_wen,
  input  wire logic [ipireg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [ipireg_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [ERROR_WIDTH-1:0]          error_in,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [ipireg_pkg::DRIVE_WIDTH-1:0]   drive_out
);
  import ipireg_pkg::*;

  cfg_t                          cfg;
  logic                          s1_valid;
  logic signed [ERROR_WIDTH-1:0] s1_error;
  logic                          advance;
  logic                          in_take;
  logic signed [DRIVE_WIDTH-1:0] drive_next;

  ipireg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Flow control: stage 1 moves when the result register is free or draining
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_error <= error_in;
    end
  end

  ipireg_core #(
    .ERROR_WIDTH (ERROR_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .update     (s1_valid && advance),
    .error      (s1_error),
    .drive_next (drive_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      drive_out <= drive_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/incremental_pi_regulator_test.sv -----
// Self-checking testbench for the incremental PI regulator with output clamp.
`timescale 1ns / 1ps

module incremental_pi_regulator_test;
  import ipireg_pkg::*;

  localparam int EW           = ERROR_WIDTH_DEFAULT;
  localparam int HOLD_CYCLES  = 60;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 115;

  typedef logic signed [EW-1:0]          err_word_t;
  typedef logic signed [GAIN_WIDTH-1:0]  gain_word_t;
  typedef logic signed [ACC_WIDTH-1:0]   acc_word_t;
  typedef logic signed [DRIVE_WIDTH-1:0] drive_word_t;

  // DUT ports; the inputs are known from time zero
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_wen   = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_PROP_GAIN;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  err_word_t                  error_in  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  drive_word_t                drive_out;

  incremental_pi_regulator #(.ERROR_WIDTH(EW)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .error_in  (error_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive_out (drive_out)
  );

  always #5 clk = ~clk;

  // Error samples waiting to be sent, drive values waiting to come out
  err_word_t   error_queue[$];
  drive_word_t drive_queue[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int queued_count  = 0;
  int taken_count   = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  logic beat_taken  = 1'b0;

  // Regulator mirror: registers and state
  gain_word_t prop_k;
  gain_word_t integ_k;
  acc_word_t  upper_q;
  acc_word_t  lower_q;
  err_word_t  last_err;
  acc_word_t  accum_q;

  // One regulator update: increment, accumulate, clamp (upper first)
  task automatic regulate(input err_word_t err, output drive_word_t drive);
    longint total;
    total = longint'(accum_q)
          + (longint'(err) - longint'(last_err)) * longint'(prop_k) * (64'sd1 << PROP_SHIFT)
          + longint'(err) * longint'(integ_k);
    if (total > longint'(upper_q)) begin
      total = longint'(upper_q);
    end else if (total < longint'(lower_q)) begin
      total = longint'(lower_q);
    end
    accum_q  = total[ACC_WIDTH-1:0];
    last_err = err;
    drive    = accum_q[ACC_WIDTH-1 -: DRIVE_WIDTH];
  endtask

  // Monitor: register writes, input beats, output checks, watchdog
  always @(posedge clk) begin
    drive_word_t want;
    if (rst) begin
      prop_k     = '0;
      integ_k    = '0;
      upper_q    = UPPER_LIMIT_RESET;
      lower_q    = LOWER_LIMIT_RESET;
      last_err   = '0;
      accum_q    = '0;
      beat_taken <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_PROP_GAIN:   prop_k  = cfg_data[GAIN_WIDTH-1:0];
          REG_INTEG_GAIN:  integ_k = cfg_data[GAIN_WIDTH-1:0];
          REG_UPPER_LIMIT: upper_q = cfg_data[ACC_WIDTH-1:0];
          REG_LOWER_LIMIT: lower_q = cfg_data[ACC_WIDTH-1:0];
          default: ;
        endcase
      end
      // check the output before predicting, so an early beat is caught
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          $display("%0t: unexpected drive_out beat, expected none, got %0d", $time, drive_out);
          mismatches++;
        end else begin
          want = drive_queue.pop_front();
          if (drive_out !== want) begin
            $display("%0t: drive_out expected %0d, got %0d", $time, want, drive_out);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        regulate(error_in, want);
        drive_queue.push_back(want);
        taken_count++;
      end
      beat_taken <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("incremental_pi_regulator_test: done, errors");
        $finish;
      end
    end
  end

  // Driver: next error sample once the current beat is gone
  always @(negedge clk) begin
    if (!in_valid || beat_taken) begin
      if (!rst && error_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        error_in <= error_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
        error_in <= err_word_t'($urandom);
      end
    end
  end

  // Receiver: random stall, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Gains carry junk in the unused upper bits; only the low half counts
  task automatic write_all(input gain_word_t kp, input gain_word_t ki,
                           input acc_word_t hi, input acc_word_t lo);
    write_reg(REG_PROP_GAIN,   {16'($urandom), kp});
    write_reg(REG_INTEG_GAIN,  {16'($urandom), ki});
    write_reg(REG_UPPER_LIMIT, hi);
    write_reg(REG_LOWER_LIMIT, lo);
  endtask

  // Wait until every sample went in and every drive value came out
  task automatic wait_idle();
    do @(negedge clk);
    while (error_queue.size() != 0 || taken_count != queued_count || drive_queue.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic send(input err_word_t e);
    error_queue.push_back(e);
    queued_count++;
  endtask

  function automatic gain_word_t pick_gain();
    case ($urandom_range(0, 5))
      0:       pick_gain = '0;
      1:       pick_gain = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2:       pick_gain = gain_word_t'($urandom);
      default: pick_gain = gain_word_t'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic random_config();
    acc_word_t a;
    acc_word_t b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 4))
      0: begin
        a = UPPER_LIMIT_RESET;
        b = LOWER_LIMIT_RESET;
      end
      1: begin
        // narrow window around zero
        a = $urandom_range(0, 32'h0100_0000);
        b = -acc_word_t'($urandom_range(0, 32'h0100_0000));
      end
      2: ;  // crossed or ordered, as it falls
      default: begin
        if (a < b) begin
          a = a ^ b;
          b = a ^ b;
          a = a ^ b;
        end
      end
    endcase
    write_all(pick_gain(), pick_gain(), a, b);
  endtask

  // Mix of extremes, small values, a random walk and full-range noise
  task automatic random_errors(input int count);
    err_word_t walk;
    walk = err_word_t'($urandom);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       send(16'sh7FFF);
        1:       send(16'sh8000);
        2, 3:    send(err_word_t'(int'($urandom_range(0, 64)) - 32));
        4, 5, 6: begin
          walk = walk + err_word_t'(int'($urandom_range(0, 512)) - 256);
          send(walk);
        end
        default: send(err_word_t'($urandom));
      endcase
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 63;

    // unit gains, full range
    write_all(16'sd1, 16'sd1, UPPER_LIMIT_RESET, LOWER_LIMIT_RESET);
    send(16'sd0);
    send(16'sh7FFF);
    send(16'sh8000);
    send(16'sh7FFF);
    send(16'sd1);
    send(-16'sd1);
    send(16'sd0);
    wait_idle();

    // largest positive gains: both clamps hit at full range
    write_all(16'sh7FFF, 16'sh7FFF, UPPER_LIMIT_RESET, LOWER_LIMIT_RESET);
    send(16'sh7FFF);
    send(16'sh8000);
    send(16'sh7FFF);
    send(16'sh8000);
    send(16'sd0);
    send(16'sh8000);
    wait_idle();

    // most negative gains against a narrow window
    write_all(16'sh8000, 16'sh8000, 32'sh0010_0000, -32'sh0010_0000);
    send(16'sd1000);
    send(-16'sd1000);
    send(16'sh7FFF);
    send(16'sh8000);
    send(16'sd5);
    wait_idle();

    // crossed limits: anything not above the upper limit lands on the lower
    write_all(16'sd3, -16'sd7, -32'sh0001_0000, 32'sh0002_0000);
    send(16'sd0);
    send(16'sd100);
    send(-16'sd100);
    send(16'sd0);
    wait_idle();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 63 : 0;
      recv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 29 : 0;
      for (int ph = 0; ph < 2; ph++) begin
        random_config();
        // long receiver hold-off while the sender keeps offering beats
        if (mode == 2 && ph == 0) begin
          hold_requests++;
        end
        random_errors(PHASE_ITEMS);
        wait_idle();
      end
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("incremental_pi_regulator_test: done, clean");
    end else begin
      $display("incremental_pi_regulator_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- incremental_pi_regulator.f -----
hdl/ipireg_pkg.sv
hdl/ipireg_cfg.sv
hdl/ipireg_core.sv
hdl/incremental_pi_regulator.sv
tb/sv/incremental_pi_regulator_test.sv
